// File: hdl/lr_pkg.sv
// ----------------------------------------------------------------------------
// Line rasterizer package
// Shared constants and types for the line rasterizer.
// ----------------------------------------------------------------------------
package lr_pkg;

    localparam int COORD_BITS_DEF = 11;
    localparam int COLOR_BITS     = 8;
    localparam int RGB_BITS       = 3 * COLOR_BITS;

    // Operation codes carried on the input tuser.
    localparam logic OP_START = 1'b0;
    localparam logic OP_NEXT  = 1'b1;

    // Control group handed from the input register to the step core.
    typedef struct packed {
        logic valid;
        logic op;
        logic xneg;
        logic yneg;
    } lr_ctrl_t;

endpackage

// File: hdl/lr_input_stage.sv
// ----------------------------------------------------------------------------
// Line rasterizer input register
// Registers an accepted beat and works out the absolute deltas and step
// directions of the endpoints on the way in.
// ----------------------------------------------------------------------------
module lr_input_stage
    import lr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  in_op,
    input  logic [COORD_BITS-1:0] in_start_x,
    input  logic [COORD_BITS-1:0] in_start_y,
    input  logic [COORD_BITS-1:0] in_end_x,
    input  logic [COORD_BITS-1:0] in_end_y,
    input  logic [RGB_BITS-1:0]   in_color,
    input  logic                  take,
    output lr_ctrl_t              ctrl,
    output logic [COORD_BITS-1:0] start_x,
    output logic [COORD_BITS-1:0] start_y,
    output logic [COORD_BITS-1:0] end_x,
    output logic [COORD_BITS-1:0] end_y,
    output logic [COORD_BITS-1:0] abs_dx,
    output logic [COORD_BITS-1:0] abs_dy,
    output logic [RGB_BITS-1:0]   color
);

    logic                  vld_reg;
    logic                  op_reg;
    logic                  xneg_reg;
    logic                  yneg_reg;
    logic [COORD_BITS-1:0] sx_reg;
    logic [COORD_BITS-1:0] sy_reg;
    logic [COORD_BITS-1:0] ex_reg;
    logic [COORD_BITS-1:0] ey_reg;
    logic [COORD_BITS-1:0] adx_reg;
    logic [COORD_BITS-1:0] ady_reg;
    logic [RGB_BITS-1:0]   color_reg;

    logic                  xneg_next;
    logic                  yneg_next;
    logic [COORD_BITS-1:0] adx_next;
    logic [COORD_BITS-1:0] ady_next;

    assign in_ready = !vld_reg || take;

    always_comb
    begin
        xneg_next = in_end_x < in_start_x;
        yneg_next = in_end_y < in_start_y;
        adx_next  = xneg_next ? (in_start_x - in_end_x) : (in_end_x - in_start_x);
        ady_next  = yneg_next ? (in_start_y - in_end_y) : (in_end_y - in_start_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg    <= in_op;
            xneg_reg  <= xneg_next;
            yneg_reg  <= yneg_next;
            sx_reg    <= in_start_x;
            sy_reg    <= in_start_y;
            ex_reg    <= in_end_x;
            ey_reg    <= in_end_y;
            adx_reg   <= adx_next;
            ady_reg   <= ady_next;
            color_reg <= in_color;
        end
    end

    assign ctrl.valid = vld_reg;
    assign ctrl.op    = op_reg;
    assign ctrl.xneg  = xneg_reg;
    assign ctrl.yneg  = yneg_reg;
    assign start_x    = sx_reg;
    assign start_y    = sy_reg;
    assign end_x      = ex_reg;
    assign end_y      = ey_reg;
    assign abs_dx     = adx_reg;
    assign abs_dy     = ady_reg;
    assign color      = color_reg;

endmodule

// File: hdl/lr_step_core.sv
// ----------------------------------------------------------------------------
// Line rasterizer step core
// Holds the line state, loads it on a start beat, takes one Bresenham step per
// next beat of an active line and registers the pixel for the output stream.
// ----------------------------------------------------------------------------
module lr_step_core
    import lr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lr_ctrl_t              ctrl,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    input  logic [COORD_BITS-1:0] abs_dx,
    input  logic [COORD_BITS-1:0] abs_dy,
    input  logic [RGB_BITS-1:0]   color,
    output logic                  take,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic [RGB_BITS-1:0]   pixel_color,
    output logic                  pixel_valid,
    output logic                  pixel_last
);

    localparam int ERR_BITS = COORD_BITS + 2;

    // Line state
    logic [COORD_BITS-1:0]      cur_major_reg, cur_major_next;
    logic [COORD_BITS-1:0]      cur_minor_reg, cur_minor_next;
    logic [COORD_BITS-1:0]      stop_major_reg, stop_major_next;
    logic signed [ERR_BITS-1:0] err_reg, err_next;
    logic [COORD_BITS-1:0]      amaj_reg, amaj_next;
    logic [COORD_BITS-1:0]      amin_reg, amin_next;
    logic                       maj_neg_reg, maj_neg_next;
    logic                       min_neg_reg, min_neg_next;
    logic                       x_major_reg, x_major_next;
    logic                       active_reg, active_next;
    logic [RGB_BITS-1:0]        color_reg, color_next;

    // Result register
    logic                  ovld_reg;
    logic [COORD_BITS-1:0] px_reg, px_next;
    logic [COORD_BITS-1:0] py_reg, py_next;
    logic [RGB_BITS-1:0]   pcol_reg, pcol_next;
    logic                  pvalid_reg, pvalid_next;
    logic                  plast_reg, plast_next;

    logic                  advance;
    logic                  x_wins;
    logic                  emit;

    assign take    = !ovld_reg || out_ready;
    assign advance = ctrl.valid && take;
    assign x_wins  = abs_dx >= abs_dy;

    always_comb
    begin
        cur_major_next  = cur_major_reg;
        cur_minor_next  = cur_minor_reg;
        stop_major_next = stop_major_reg;
        err_next        = err_reg;
        amaj_next       = amaj_reg;
        amin_next       = amin_reg;
        maj_neg_next    = maj_neg_reg;
        min_neg_next    = min_neg_reg;
        x_major_next    = x_major_reg;
        active_next     = active_reg;
        color_next      = color_reg;
        emit            = 1'b0;

        if (ctrl.op == OP_START)
        begin
            emit         = 1'b1;
            color_next   = color;
            x_major_next = x_wins;
            if (x_wins)
            begin
                cur_major_next  = start_x;
                cur_minor_next  = start_y;
                stop_major_next = end_x;
                amaj_next       = abs_dx;
                amin_next       = abs_dy;
                maj_neg_next    = ctrl.xneg;
                min_neg_next    = ctrl.yneg;
            end
            else
            begin
                cur_major_next  = start_y;
                cur_minor_next  = start_x;
                stop_major_next = end_y;
                amaj_next       = abs_dy;
                amin_next       = abs_dx;
                maj_neg_next    = ctrl.yneg;
                min_neg_next    = ctrl.xneg;
            end
            err_next    = $signed({2'b00, amin_next}) - $signed({2'b00, amaj_next});
            active_next = cur_major_next != stop_major_next;
        end
        else if (active_reg)
        begin
            emit = 1'b1;
            // A non-negative error means the minor coordinate moves this step.
            if (!err_reg[ERR_BITS-1])
            begin
                cur_minor_next = min_neg_reg ? (cur_minor_reg - 1'b1)
                                             : (cur_minor_reg + 1'b1);
                err_next = err_reg - $signed({2'b00, amaj_reg})
                                   + $signed({2'b00, amin_reg});
            end
            else
            begin
                err_next = err_reg + $signed({2'b00, amin_reg});
            end
            cur_major_next = maj_neg_reg ? (cur_major_reg - 1'b1)
                                         : (cur_major_reg + 1'b1);
            active_next    = cur_major_next != stop_major_reg;
        end

        if (emit)
        begin
            px_next     = x_major_next ? cur_major_next : cur_minor_next;
            py_next     = x_major_next ? cur_minor_next : cur_major_next;
            pcol_next   = color_next;
            pvalid_next = 1'b1;
            plast_next  = !active_next;
        end
        else
        begin
            px_next     = '0;
            py_next     = '0;
            pcol_next   = '0;
            pvalid_next = 1'b0;
            plast_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_major_reg  <= '0;
            cur_minor_reg  <= '0;
            stop_major_reg <= '0;
            err_reg        <= '0;
            amaj_reg       <= '0;
            amin_reg       <= '0;
            maj_neg_reg    <= 1'b0;
            min_neg_reg    <= 1'b0;
            x_major_reg    <= 1'b1;
            active_reg     <= 1'b0;
            color_reg      <= '0;
            ovld_reg       <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                ovld_reg <= ctrl.valid;
            end
            if (advance)
            begin
                cur_major_reg  <= cur_major_next;
                cur_minor_reg  <= cur_minor_next;
                stop_major_reg <= stop_major_next;
                err_reg        <= err_next;
                amaj_reg       <= amaj_next;
                amin_reg       <= amin_next;
                maj_neg_reg    <= maj_neg_next;
                min_neg_reg    <= min_neg_next;
                x_major_reg    <= x_major_next;
                active_reg     <= active_next;
                color_reg      <= color_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            px_reg     <= px_next;
            py_reg     <= py_next;
            pcol_reg   <= pcol_next;
            pvalid_reg <= pvalid_next;
            plast_reg  <= plast_next;
        end
    end

    assign out_valid   = ovld_reg;
    assign pixel_x     = px_reg;
    assign pixel_y     = py_reg;
    assign pixel_color = pcol_reg;
    assign pixel_valid = pvalid_reg;
    assign pixel_last  = plast_reg;

endmodule

// File: hdl/line_rasterizer_top.sv
// ----------------------------------------------------------------------------
// Line rasterizer top level
// Bresenham line drawing with a stream input of commands and a stream output
// of pixels.
// ----------------------------------------------------------------------------
// A start beat (tuser 0) loads two endpoints and a colour and returns the
// start point; every next beat (tuser 1) returns the following pixel along
// the major axis, with tlast on the end point. A next beat with no line in
// progress returns a beat with tuser 0 and all data zero. Every input beat
// gives exactly one output beat, one beat per clock cycle is sustained while
// the output is ready, and a result passes through the input register, where
// the endpoint deltas are formed, and then the step core's result register,
// which takes the error update, compare and end check for each pixel.
module line_rasterizer_top
    import lr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // start_x, start_y, end_x, end_y, red, green, blue, zero fill
    input  logic [((4*COORD_BITS+RGB_BITS+7)/8)*8-1:0] s_axis_tdata,
    // op
    input  logic s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // pixel_x, pixel_y, pixel_red, pixel_green, pixel_blue, zero fill
    output logic [((2*COORD_BITS+RGB_BITS+7)/8)*8-1:0] m_axis_tdata,
    // valid_res
    output logic m_axis_tuser,
    output logic m_axis_tlast
);

    localparam int C         = COORD_BITS;
    localparam int OUT_BITS  = ((2*COORD_BITS+RGB_BITS+7)/8)*8;
    localparam int OUT_USED  = 2*COORD_BITS + RGB_BITS;

    lr_ctrl_t        ctrl;
    logic [C-1:0]    sx, sy, ex, ey, adx, ady;
    logic [RGB_BITS-1:0] color;
    logic [RGB_BITS-1:0] in_color;
    logic            take;
    logic [C-1:0]    pixel_x, pixel_y;
    logic [RGB_BITS-1:0] pixel_color;

    // Colour is held red high, blue low; on the bus red comes first.
    assign in_color = {s_axis_tdata[4*C +: COLOR_BITS],
                       s_axis_tdata[4*C+COLOR_BITS +: COLOR_BITS],
                       s_axis_tdata[4*C+2*COLOR_BITS +: COLOR_BITS]};

    lr_input_stage #(
        .COORD_BITS (COORD_BITS)
    ) u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_op      (s_axis_tuser),
        .in_start_x (s_axis_tdata[0 +: C]),
        .in_start_y (s_axis_tdata[C +: C]),
        .in_end_x   (s_axis_tdata[2*C +: C]),
        .in_end_y   (s_axis_tdata[3*C +: C]),
        .in_color   (in_color),
        .take       (take),
        .ctrl       (ctrl),
        .start_x    (sx),
        .start_y    (sy),
        .end_x      (ex),
        .end_y      (ey),
        .abs_dx     (adx),
        .abs_dy     (ady),
        .color      (color)
    );

    lr_step_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .start_x     (sx),
        .start_y     (sy),
        .end_x       (ex),
        .end_y       (ey),
        .abs_dx      (adx),
        .abs_dy      (ady),
        .color       (color),
        .take        (take),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .pixel_valid (m_axis_tuser),
        .pixel_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {{(OUT_BITS-OUT_USED){1'b0}},
                           pixel_color[0 +: COLOR_BITS],
                           pixel_color[COLOR_BITS +: COLOR_BITS],
                           pixel_color[2*COLOR_BITS +: COLOR_BITS],
                           pixel_y,
                           pixel_x};

endmodule

// File: verif/line_rasterizer_top_tb.sv
// ----------------------------------------------------------------------------
// Line rasterizer testbench
// Streams line commands into the rasterizer and checks every pixel beat
// against a cycle-free Bresenham predictor kept inside the bench. Directed
// lines cover the corners, shallow and steep lines, the tie case, single
// points, abandoned lines and next beats with no line; random lines follow.
// ----------------------------------------------------------------------------
module line_rasterizer_top_tb;
    import lr_pkg::*;

    localparam int CW        = COORD_BITS_DEF;
    localparam int IN_W      = ((4*CW+RGB_BITS+7)/8)*8;
    localparam int OUT_W     = ((2*CW+RGB_BITS+7)/8)*8;
    localparam int CMAX      = (1 << CW) - 1;
    localparam int ITEMS     = 2000;
    localparam int STALL_MAX = 5000;

    typedef struct packed {
        logic          op;
        logic [CW-1:0] sx;
        logic [CW-1:0] sy;
        logic [CW-1:0] ex;
        logic [CW-1:0] ey;
        logic [7:0]    r;
        logic [7:0]    g;
        logic [7:0]    b;
    } line_cmd_t;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [7:0]    r;
        logic [7:0]    g;
        logic [7:0]    b;
        logic          on;
        logic          tail;
    } pixel_t;

    logic             clk;
    logic             rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata;
    logic             s_axis_tuser;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;
    logic             m_axis_tuser;
    logic             m_axis_tlast;

    // Predictor state for the line being walked.
    logic [CW-1:0] walk_major;
    logic [CW-1:0] walk_minor;
    logic [CW-1:0] walk_stop;
    int            walk_err;
    logic [CW-1:0] span_major;
    logic [CW-1:0] span_minor;
    bit            major_down;
    bit            minor_down;
    bit            x_leads;
    bit            line_on;
    logic [7:0]    ink_r;
    logic [7:0]    ink_g;
    logic [7:0]    ink_b;

    pixel_t expected_pixels[$];
    int     beats_sent;
    int     fail_count;
    int     stall_cycles;
    bit     steady;

    line_rasterizer_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic pixel_t trace_pixel(line_cmd_t c);
        pixel_t        p;
        logic [CW-1:0] adx;
        logic [CW-1:0] ady;
        p = '0;
        if (c.op == OP_START)
        begin
            adx = (c.ex >= c.sx) ? c.ex - c.sx : c.sx - c.ex;
            ady = (c.ey >= c.sy) ? c.ey - c.sy : c.sy - c.ey;
            ink_r = c.r;
            ink_g = c.g;
            ink_b = c.b;
            x_leads = (adx >= ady);
            if (x_leads)
            begin
                walk_major = c.sx; walk_minor = c.sy; walk_stop = c.ex;
                span_major = adx;  span_minor = ady;
                major_down = (c.ex < c.sx); minor_down = (c.ey < c.sy);
            end
            else
            begin
                walk_major = c.sy; walk_minor = c.sx; walk_stop = c.ey;
                span_major = ady;  span_minor = adx;
                major_down = (c.ey < c.sy); minor_down = (c.ex < c.sx);
            end
            walk_err = int'(span_minor) - int'(span_major);
        end
        else if (!line_on)
            return p;
        else
        begin
            if (walk_err >= 0)
            begin
                walk_minor = minor_down ? walk_minor - 1'b1 : walk_minor + 1'b1;
                walk_err -= int'(span_major);
            end
            walk_err += int'(span_minor);
            walk_major = major_down ? walk_major - 1'b1 : walk_major + 1'b1;
        end
        line_on = (walk_major != walk_stop);
        p.x    = x_leads ? walk_major : walk_minor;
        p.y    = x_leads ? walk_minor : walk_major;
        p.r    = ink_r;
        p.g    = ink_g;
        p.b    = ink_b;
        p.on   = 1'b1;
        p.tail = !line_on;
        return p;
    endfunction

    // Drives one command beat and records the pixel it must produce.
    task automatic send_beat(line_cmd_t c);
        logic [IN_W-1:0] word;
        word = '0;
        word[4*CW+RGB_BITS-1:0] = {c.b, c.g, c.r, c.ey, c.ex, c.sy, c.sx};
        @(negedge clk);
        while (!steady && $urandom_range(99) < 18)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= c.op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_pixels.push_back(trace_pixel(c));
        beats_sent++;
    endtask

    function automatic line_cmd_t random_cmd(logic op);
        line_cmd_t   c;
        logic [95:0] noise;
        noise = {$urandom, $urandom, $urandom};
        c     = noise[$bits(line_cmd_t)-1:0];
        c.op  = op;
        return c;
    endfunction

    function automatic line_cmd_t make_line(int x0, int y0, int x1, int y1,
                                            logic [7:0] r, logic [7:0] g,
                                            logic [7:0] b);
        line_cmd_t c;
        c = '{op: OP_START, sx: CW'(x0), sy: CW'(y0), ex: CW'(x1), ey: CW'(y1),
              r: r, g: g, b: b};
        return c;
    endfunction

    // Picks an end coordinate within reach of the start, staying on the grid.
    function automatic logic [CW-1:0] near(logic [CW-1:0] s, int reach);
        int d;
        int e;
        d = $urandom_range(reach);
        if ($urandom_range(1))
            e = (int'(s) + d > CMAX) ? int'(s) - d : int'(s) + d;
        else
            e = (int'(s) < d) ? int'(s) + d : int'(s) - d;
        return CW'(e);
    endfunction

    // Starts a line and asks for pixels until it ends or the budget runs out.
    task automatic draw_line(line_cmd_t c, int max_next);
        int n;
        n = 0;
        send_beat(c);
        while (line_on && n < max_next)
        begin
            send_beat(random_cmd(OP_NEXT));
            n++;
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_idle_next();
        send_beat(random_cmd(OP_NEXT));
    endtask

    task automatic test_single_points();
        send_beat(make_line(0, 0, 0, 0, 8'h00, 8'h00, 8'h00));
        send_beat(random_cmd(OP_NEXT));
        send_beat(make_line(CMAX, CMAX, CMAX, CMAX, 8'hFF, 8'hFF, 8'hFF));
    endtask

    task automatic test_octants();
        // Shallow line from the origin, then one next beat past its end.
        draw_line(make_line(0, 0, 3, 1, 8'hFF, 8'h00, 8'hAA), 10);
        send_beat(random_cmd(OP_NEXT));
        // Steep line walking back from the far corner.
        draw_line(make_line(CMAX, CMAX, CMAX-1, CMAX-3, 8'h00, 8'hFF, 8'h55), 10);
        // Equal deltas keep x as the major axis.
        draw_line(make_line(5, 5, 3, 7, 8'h80, 8'h01, 8'hFE), 1);
    endtask

    task automatic test_abandon();
        draw_line(make_line(0, CMAX, 2, CMAX-1, 8'h7F, 8'h80, 8'h01), 10);
        draw_line(make_line(CMAX, 0, CMAX-40, 17, 8'h12, 8'h34, 8'h56), 2);
        draw_line(make_line(10, 20, 12, 25, 8'hC3, 8'h3C, 8'h99), 10);
    endtask

    // One long line from a corner at full rate on both sides.
    task automatic test_full_span();
        steady = 1'b1;
        draw_line(make_line(0, CMAX, 299, CMAX-120, 8'hA5, 8'h5A, 8'h0F), CMAX + 2);
        steady = 1'b0;
    endtask

    task automatic test_random_lines(int target);
        line_cmd_t c;
        int        pick;
        int        reach;
        while (beats_sent < target)
        begin
            pick  = $urandom_range(99);
            reach = ($urandom_range(9) == 0) ? 200 : 20;
            c     = random_cmd(OP_START);
            c.ex  = near(c.sx, reach);
            c.ey  = near(c.sy, reach);
            if (pick < 65)
                draw_line(c, 1 << CW);
            else if (pick < 80)
                draw_line(c, $urandom_range(reach / 2));
            else if (pick < 85)
            begin
                c.ex = c.sx;
                c.ey = c.sy;
                draw_line(c, 0);
            end
            else if (pick < 90)
                draw_line(random_cmd(OP_START), $urandom_range(30));
            else
                send_beat(random_cmd(1'($urandom_range(1))));
        end
    endtask

    task automatic test_drain_pause();
        draw_line(make_line(100, 100, 90, 130, 8'h11, 8'h22, 8'h33), 1 << CW);
        wait_drained();
        draw_line(make_line(300, 200, 330, 195, 8'h44, 8'h55, 8'h66), 1 << CW);
    endtask

    always @(negedge clk)
        m_axis_tready <= steady ? 1'b1 : ($urandom_range(99) >= 18);

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected pixel beat, expected none, actual %0h",
                         $time, m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                check_field("pixel_x", int'(want.x), int'(m_axis_tdata[CW-1:0]));
                check_field("pixel_y", int'(want.y), int'(m_axis_tdata[2*CW-1:CW]));
                check_field("pixel_red", int'(want.r),
                            int'(m_axis_tdata[2*CW+7:2*CW]));
                check_field("pixel_green", int'(want.g),
                            int'(m_axis_tdata[2*CW+15:2*CW+8]));
                check_field("pixel_blue", int'(want.b),
                            int'(m_axis_tdata[2*CW+23:2*CW+16]));
                check_field("valid_res", int'(want.on), int'(m_axis_tuser));
                check_field("last", int'(want.tail), int'(m_axis_tlast));
                check_field("fill", 0, int'(m_axis_tdata[OUT_W-1:2*CW+RGB_BITS]));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX)
        begin
            $display("line_rasterizer_top_tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_START;
        m_axis_tready = 1'b0;
        beats_sent    = 0;
        fail_count    = 0;
        stall_cycles  = 0;
        steady        = 1'b0;
        walk_major    = '0;
        walk_minor    = '0;
        walk_stop     = '0;
        walk_err      = 0;
        span_major    = '0;
        span_minor    = '0;
        major_down    = 1'b0;
        minor_down    = 1'b0;
        x_leads       = 1'b1;
        line_on       = 1'b0;
        ink_r         = '0;
        ink_g         = '0;
        ink_b         = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_idle_next();
        test_single_points();
        test_octants();
        test_abandon();
        test_random_lines(ITEMS / 2);
        test_drain_pause();
        test_full_span();
        test_random_lines(ITEMS);

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("line_rasterizer_top_tb OK");
        else
            $display("line_rasterizer_top_tb NOT OK");
        $finish;
    end

endmodule
